// File: design/cbf_pkg.sv
// Shared types, character codes and status codes of the closing brace finder.
`default_nettype none

package cbf_pkg;

    localparam int INDEX_BITS_DEFAULT   = 16;
    localparam int QUEUE_DEPTH_DEFAULT  = 4;
    localparam int RESULT_DEPTH_DEFAULT = 2;
    localparam int BYTE_BITS            = 8;
    localparam int INDEX_OUT_BITS       = 16;

    localparam logic [BYTE_BITS-1:0] CHAR_OPEN_CURLY  = 8'h7B;
    localparam logic [BYTE_BITS-1:0] CHAR_OPEN_PAREN  = 8'h28;
    localparam logic [BYTE_BITS-1:0] CHAR_CLOSE_CURLY = 8'h7D;
    localparam logic [BYTE_BITS-1:0] CHAR_CLOSE_PAREN = 8'h29;
    localparam logic [BYTE_BITS-1:0] CHAR_DQUOTE      = 8'h22;
    localparam logic [BYTE_BITS-1:0] CHAR_SQUOTE      = 8'h27;
    localparam logic [BYTE_BITS-1:0] CHAR_BQUOTE      = 8'h60;
    localparam logic [BYTE_BITS-1:0] CHAR_BACKSLASH   = 8'h5C;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;
    localparam logic [1:0] QUOTE_BACK   = 2'd3;

    localparam logic [1:0] STATUS_MATCH    = 2'd0;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [1:0] STATUS_BAD_OPEN = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [BYTE_BITS-1:0] byte_req;
        logic                 last;
    } cbf_req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [INDEX_OUT_BITS-1:0] index;
    } cbf_rsp_t;

    // One byte after classification
    typedef struct packed {
        logic       open_curly;
        logic       open_paren;
        logic       close_curly;
        logic       close_paren;
        logic [1:0] quote;
        logic       backslash;
        logic       last;
    } cbf_class_t;

endpackage

`default_nettype wire

// File: design/closing_brace_finder.sv
// Top level of the closing brace finder: front end, back end and result queue.
//
// Usage: a string enters one byte per item on the request channel (push/full),
// the final byte flagged by request.last. The first byte must be '{' or '('.
// Each string yields exactly one item on the response channel (empty/pop):
// status 0 with the index of the matching closing bracket, 1 for no match or
// an unclosed quote, 2 for a bad opening byte, 3 when the string outruns the
// index range. Bytes after the result are dropped up to the flagged last byte.
// Throughput: one byte per cycle while the result queue has room, set by the
// back end, which updates its nesting and quote state for each byte it takes.
// A result appears (empty low) once the byte that decides it has passed both
// queues: the byte is written into the classified-byte queue, and the back end
// takes it from there when the result queue has room and writes the result
// into the result queue in the same cycle.
// Reset: all queues empty, the block waits for the first byte of a string.
// Stalls: when pop is held low the result queue fills, the back end holds,
// and the byte queue then fills and raises full; no item is lost.
`default_nettype none

module closing_brace_finder #(
    parameter int INDEX_BITS   = cbf_pkg::INDEX_BITS_DEFAULT,
    parameter int QUEUE_DEPTH  = cbf_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int RESULT_DEPTH = cbf_pkg::RESULT_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire cbf_pkg::cbf_req_t request,
    output logic                   empty,
    input  wire logic              pop,
    output cbf_pkg::cbf_rsp_t      response
);

    localparam int RSP_BITS = $bits(cbf_pkg::cbf_rsp_t);

    logic                cls_valid;
    logic                cls_pop;
    cbf_pkg::cbf_class_t cls_item;
    logic                rsp_full;
    logic                rsp_push;
    cbf_pkg::cbf_rsp_t   rsp_item;
    logic [RSP_BITS-1:0] rsp_rd_data;

    // Classify bytes and buffer them
    cbf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cls_pop   (cls_pop),
        .cls_valid (cls_valid),
        .cls_item  (cls_item)
    );

    // Track nesting and quotes, decide the outcome of each string
    cbf_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (cls_valid),
        .cls_item  (cls_item),
        .cls_pop   (cls_pop),
        .rsp_full  (rsp_full),
        .rsp_push  (rsp_push),
        .rsp_item  (rsp_item)
    );

    // Hold results until the receiver takes them
    cbf_fifo #(
        .WIDTH (RSP_BITS),
        .DEPTH (RESULT_DEPTH)
    ) u_rsp_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rsp_push),
        .wr_data (rsp_item),
        .full    (rsp_full),
        .rd_en   (pop),
        .rd_data (rsp_rd_data),
        .empty   (empty)
    );

    assign response = cbf_pkg::cbf_rsp_t'(rsp_rd_data);

`ifndef SYNTHESIS
    // Only a match carries a non-zero index
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (response.status == cbf_pkg::STATUS_MATCH || response.index == '0))
        else $error("non-match result with non-zero index");

    // A byte accepted into an empty front queue is visible to the back end next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !cls_valid) |=> cls_valid)
        else $error("accepted byte lost in front queue");

    // The back end never produces a result while the result queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_push |-> !rsp_full)
        else $error("result produced into a full queue");

    // The back end consumes only bytes that are present
    assert property (@(posedge clk) disable iff (!rst_n)
        cls_pop |-> cls_valid)
        else $error("back end consumed from an empty queue");
`endif

endmodule

`default_nettype wire

// File: design/cbf_fifo.sv
// Generic register queue with first-word-fall-through read.
`default_nettype none

module cbf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                wr_fire;
    logic                rd_fire;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({wr_fire, rd_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: design/cbf_front.sv
// Front end: classify each incoming byte and queue it for the back end.
`default_nettype none

module cbf_front #(
    parameter int QUEUE_DEPTH = cbf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire cbf_pkg::cbf_req_t request,
    input  wire logic              cls_pop,
    output logic                   cls_valid,
    output cbf_pkg::cbf_class_t    cls_item
);

    localparam int CLS_BITS = $bits(cbf_pkg::cbf_class_t);

    cbf_pkg::cbf_class_t cls_in;
    logic [CLS_BITS-1:0] cls_rd_data;
    logic                cls_empty;

    always_comb
    begin
        cls_in.open_curly  = (request.byte_req == cbf_pkg::CHAR_OPEN_CURLY);
        cls_in.open_paren  = (request.byte_req == cbf_pkg::CHAR_OPEN_PAREN);
        cls_in.close_curly = (request.byte_req == cbf_pkg::CHAR_CLOSE_CURLY);
        cls_in.close_paren = (request.byte_req == cbf_pkg::CHAR_CLOSE_PAREN);
        cls_in.backslash   = (request.byte_req == cbf_pkg::CHAR_BACKSLASH);
        cls_in.last        = request.last;
        unique case (request.byte_req)
            cbf_pkg::CHAR_SQUOTE: cls_in.quote = cbf_pkg::QUOTE_SINGLE;
            cbf_pkg::CHAR_DQUOTE: cls_in.quote = cbf_pkg::QUOTE_DOUBLE;
            cbf_pkg::CHAR_BQUOTE: cls_in.quote = cbf_pkg::QUOTE_BACK;
            default:              cls_in.quote = cbf_pkg::QUOTE_NONE;
        endcase
    end

    cbf_fifo #(
        .WIDTH (CLS_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_cls_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (cls_pop),
        .rd_data (cls_rd_data),
        .empty   (cls_empty)
    );

    assign cls_valid = !cls_empty;
    assign cls_item  = cbf_pkg::cbf_class_t'(cls_rd_data);

endmodule

`default_nettype wire

// File: design/cbf_back.sv
// Back end: nesting and quote tracking over classified bytes, result generation.
`default_nettype none

module cbf_back #(
    parameter int INDEX_BITS = cbf_pkg::INDEX_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cls_valid,
    input  wire cbf_pkg::cbf_class_t cls_item,
    output logic                     cls_pop,
    input  wire logic                rsp_full,
    output logic                     rsp_push,
    output cbf_pkg::cbf_rsp_t        rsp_item
);

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_SCAN  = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;

    logic [1:0]            phase_reg, phase_next;
    logic [INDEX_BITS-1:0] pos_reg, pos_next;
    logic [INDEX_BITS:0]   nest_reg, nest_next;
    logic                  curly_reg, curly_next;
    logic [1:0]            quote_reg, quote_next;
    logic                  bslash_reg, bslash_next;
    logic [INDEX_BITS-1:0] pos_inc;
    logic                  open_hit;
    logic                  close_hit;

    // Advance only when a result, if any, has room to land
    assign cls_pop   = cls_valid && !rsp_full;
    assign pos_inc   = pos_reg + 1'b1;
    assign open_hit  = curly_reg ? cls_item.open_curly : cls_item.open_paren;
    assign close_hit = curly_reg ? cls_item.close_curly : cls_item.close_paren;

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        nest_next       = nest_reg;
        curly_next      = curly_reg;
        quote_next      = quote_reg;
        bslash_next     = bslash_reg;
        rsp_push        = 1'b0;
        rsp_item.status = cbf_pkg::STATUS_MATCH;
        rsp_item.index  = '0;
        if (cls_pop)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    pos_next   = '0;
                    quote_next = cbf_pkg::QUOTE_NONE;
                    if (cls_item.open_curly || cls_item.open_paren)
                    begin
                        curly_next = cls_item.open_curly;
                        nest_next  = (INDEX_BITS + 1)'(1);
                        phase_next = PH_SCAN;
                    end
                    else
                    begin
                        nest_next       = '0;
                        rsp_push        = 1'b1;
                        rsp_item.status = cbf_pkg::STATUS_BAD_OPEN;
                        phase_next      = PH_SKIP;
                    end
                    bslash_next = cls_item.backslash;
                end
                PH_SCAN:
                begin
                    pos_next = pos_inc;
                    if (&pos_reg)
                    begin
                        rsp_push        = 1'b1;
                        rsp_item.status = cbf_pkg::STATUS_OVERFLOW;
                        phase_next      = PH_SKIP;
                    end
                    else
                    begin
                        if (quote_reg != cbf_pkg::QUOTE_NONE)
                        begin
                            if (cls_item.quote == quote_reg && !bslash_reg)
                            begin
                                quote_next = cbf_pkg::QUOTE_NONE;
                            end
                        end
                        else if (cls_item.quote != cbf_pkg::QUOTE_NONE)
                        begin
                            if (!bslash_reg)
                            begin
                                quote_next = cls_item.quote;
                            end
                        end
                        else if (!bslash_reg)
                        begin
                            if (open_hit)
                            begin
                                nest_next = nest_reg + 1'b1;
                            end
                            else if (close_hit)
                            begin
                                nest_next = nest_reg - 1'b1;
                                if (nest_reg == (INDEX_BITS + 1)'(1))
                                begin
                                    rsp_push        = 1'b1;
                                    rsp_item.status = cbf_pkg::STATUS_MATCH;
                                    rsp_item.index  = cbf_pkg::INDEX_OUT_BITS'(pos_inc);
                                    phase_next      = PH_SKIP;
                                end
                            end
                        end
                        bslash_next = cls_item.backslash;
                    end
                end
                default:
                begin
                    // Skip bytes until the end of the string
                end
            endcase
            if (phase_next == PH_SCAN && cls_item.last && !rsp_push)
            begin
                rsp_push        = 1'b1;
                rsp_item.status = cbf_pkg::STATUS_NO_MATCH;
                rsp_item.index  = '0;
            end
            if (cls_item.last)
            begin
                phase_next  = PH_FIRST;
                quote_next  = cbf_pkg::QUOTE_NONE;
                bslash_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            pos_reg    <= '0;
            nest_reg   <= '0;
            curly_reg  <= 1'b0;
            quote_reg  <= cbf_pkg::QUOTE_NONE;
            bslash_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            nest_reg   <= nest_next;
            curly_reg  <= curly_next;
            quote_reg  <= quote_next;
            bslash_reg <= bslash_next;
        end
    end

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the closing brace finder: scripted and random strings.
`timescale 1ns / 1ps

module tb;
    import cbf_pkg::*;

    localparam int INDEX_BITS = INDEX_BITS_DEFAULT;
    localparam longint unsigned LAST_POS = (longint'(1) << INDEX_BITS) - 1;
    localparam int MAX_IDLE = 12;
    // Cycles the receiver holds off so that both internal queues fill and full rises
    localparam int HOLD_CYCLES = 400;
    // Cycles to wait after the last expected item
    localparam int DRAIN_CYCLES = 20;

    // Scan phase of the string being tracked
    typedef enum logic [1:0] {SEEK_OPEN, SCANNING, DRAINING} scan_phase_t;

    // One byte waiting to be offered, with the idle cycles that come before it
    typedef struct {
        cbf_req_t    req;
        int unsigned gap;
    } char_slot_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    logic     full;
    cbf_req_t request = '0;
    logic     empty;
    logic     pop = 1'b0;
    cbf_rsp_t response;

    char_slot_t  pending[$];
    cbf_rsp_t    due_results[$];
    logic [7:0]  draft[$];

    int unsigned queued_cnt = 0;
    int unsigned taken_cnt = 0;
    int unsigned result_cnt = 0;
    int unsigned fault_cnt = 0;
    int unsigned hold_at = 0;
    int unsigned idle_done = 0;
    int unsigned rx_left = 0;
    logic        req_taken = 1'b0;
    logic        rsp_taken = 1'b0;
    logic        hold_rx = 1'b0;

    // Tracked copy of the block's scan state
    scan_phase_t scan_phase = SEEK_OPEN;
    int unsigned scan_pos = 0;
    int unsigned depth = 0;
    logic        curly_kind = 1'b0;
    logic [1:0]  open_quote = QUOTE_NONE;
    logic        after_backslash = 1'b0;

    closing_brace_finder #(.INDEX_BITS(INDEX_BITS)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .empty    (empty),
        .pop      (pop),
        .response (response)
    );

    always #4 clk = ~clk;

    // Advance the tracked state by one accepted byte; found is set when it decides the string
    function void track_char(input cbf_req_t r, output bit found, output cbf_rsp_t res);
        logic [1:0] q;
        logic [7:0] opener;
        logic [7:0] closer;
        found = 1'b0;
        res = '0;
        case (r.byte_req)
            CHAR_SQUOTE: q = QUOTE_SINGLE;
            CHAR_DQUOTE: q = QUOTE_DOUBLE;
            CHAR_BQUOTE: q = QUOTE_BACK;
            default:     q = QUOTE_NONE;
        endcase
        case (scan_phase)
            SEEK_OPEN:
            begin
                scan_pos = 0;
                open_quote = QUOTE_NONE;
                if (r.byte_req == CHAR_OPEN_CURLY || r.byte_req == CHAR_OPEN_PAREN)
                begin
                    curly_kind = (r.byte_req == CHAR_OPEN_CURLY);
                    depth = 1;
                    scan_phase = SCANNING;
                end
                else
                begin
                    depth = 0;
                    found = 1'b1;
                    res.status = STATUS_BAD_OPEN;
                    scan_phase = DRAINING;
                end
                after_backslash = (r.byte_req == CHAR_BACKSLASH);
            end
            SCANNING:
            begin
                scan_pos++;
                if (scan_pos > LAST_POS)
                begin
                    found = 1'b1;
                    res.status = STATUS_OVERFLOW;
                    scan_phase = DRAINING;
                end
                else
                begin
                    opener = curly_kind ? CHAR_OPEN_CURLY : CHAR_OPEN_PAREN;
                    closer = curly_kind ? CHAR_CLOSE_CURLY : CHAR_CLOSE_PAREN;
                    if (open_quote != QUOTE_NONE)
                    begin
                        // only an unescaped quote of the same kind ends the span
                        if (q == open_quote && !after_backslash)
                            open_quote = QUOTE_NONE;
                    end
                    else if (q != QUOTE_NONE)
                    begin
                        if (!after_backslash)
                            open_quote = q;
                    end
                    else if (!after_backslash)
                    begin
                        if (r.byte_req == opener)
                            depth++;
                        else if (r.byte_req == closer)
                        begin
                            depth--;
                            if (depth == 0)
                            begin
                                found = 1'b1;
                                res.status = STATUS_MATCH;
                                res.index = scan_pos[INDEX_OUT_BITS-1:0];
                                scan_phase = DRAINING;
                            end
                        end
                    end
                    after_backslash = (r.byte_req == CHAR_BACKSLASH);
                end
            end
            default:;
        endcase
        // string ends while still open: unbalanced or an unclosed quote
        if (scan_phase == SCANNING && r.last && !found)
        begin
            found = 1'b1;
            res.status = STATUS_NO_MATCH;
        end
        if (r.last)
        begin
            scan_phase = SEEK_OPEN;
            open_quote = QUOTE_NONE;
            after_backslash = 1'b0;
        end
    endfunction

    task note_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic bit is_special(input logic [7:0] b);
        return b == CHAR_OPEN_CURLY || b == CHAR_OPEN_PAREN || b == CHAR_CLOSE_CURLY
            || b == CHAR_CLOSE_PAREN || b == CHAR_SQUOTE || b == CHAR_DQUOTE
            || b == CHAR_BQUOTE || b == CHAR_BACKSLASH;
    endfunction

    // Any byte that neither brackets, quotes nor escapes
    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (is_special(b))
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] rand_quote();
        case ($urandom_range(0, 2))
            0:       return CHAR_SQUOTE;
            1:       return CHAR_DQUOTE;
            default: return CHAR_BQUOTE;
        endcase
    endfunction

    // A byte weighted towards the characters the scanner reacts to
    function automatic logic [7:0] rand_char();
        case ($urandom_range(0, 9))
            0:       return CHAR_OPEN_CURLY;
            1:       return CHAR_CLOSE_CURLY;
            2:       return CHAR_OPEN_PAREN;
            3:       return CHAR_CLOSE_PAREN;
            4:       return rand_quote();
            5:       return CHAR_BACKSLASH;
            default: return rand_plain();
        endcase
    endfunction

    // Move the draft string into the pending queue, flagging its final byte
    task commit_string(input bit calm);
        char_slot_t slot;
        for (int i = 0; i < draft.size(); i++)
        begin
            slot.req.byte_req = draft[i];
            slot.req.last = (i == draft.size() - 1);
            slot.gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
            pending.push_back(slot);
            queued_cnt++;
        end
    endtask

    // Build a well-formed string: nested brackets, quoted spans, escapes and noise
    task make_balanced();
        logic [7:0] opener;
        logic [7:0] closer;
        logic [7:0] qc;
        logic [7:0] b;
        int unsigned level;
        bit curly;
        curly = 1'($urandom_range(0, 1));
        opener = curly ? CHAR_OPEN_CURLY : CHAR_OPEN_PAREN;
        closer = curly ? CHAR_CLOSE_CURLY : CHAR_CLOSE_PAREN;
        draft = {opener};
        level = 1;
        repeat ($urandom_range(0, 12))
        begin
            case ($urandom_range(0, 6))
                0:
                begin
                    draft.push_back(opener);
                    level++;
                end
                1:
                    if (level > 1)
                    begin
                        draft.push_back(closer);
                        level--;
                    end
                2:
                begin
                    // quoted span; a drawn quote of the same kind or a backslash becomes an escaped quote
                    qc = rand_quote();
                    draft.push_back(qc);
                    repeat ($urandom_range(0, 4))
                    begin
                        b = rand_char();
                        if (b == qc || b == CHAR_BACKSLASH)
                        begin
                            draft.push_back(CHAR_BACKSLASH);
                            draft.push_back(qc);
                        end
                        else
                            draft.push_back(b);
                    end
                    draft.push_back(qc);
                end
                3:
                begin
                    b = rand_char();
                    draft.push_back(CHAR_BACKSLASH);
                    draft.push_back(b == CHAR_BACKSLASH ? closer : b);
                end
                4:
                    // the other bracket kind never counts
                    draft.push_back(curly ? ($urandom_range(0, 1) ? CHAR_OPEN_PAREN
                                                                  : CHAR_CLOSE_PAREN)
                                          : ($urandom_range(0, 1) ? CHAR_OPEN_CURLY
                                                                  : CHAR_CLOSE_CURLY));
                default:
                    draft.push_back(rand_plain());
            endcase
        end
        repeat (level)
            draft.push_back(closer);
        // trailing bytes after the match are dropped by the block
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                draft.push_back(rand_char());
    endtask

    // Sampling at the rising edge: predict accepted bytes, check accepted results
    always @(posedge clk)
    begin
        cbf_rsp_t want;
        cbf_rsp_t res;
        bit found;
        if (rst_n)
        begin
            if (push && !full)
            begin
                track_char(request, found, res);
                if (found)
                    due_results.push_back(res);
                taken_cnt++;
            end
            if (pop && !empty)
            begin
                result_cnt++;
                if (due_results.size() == 0)
                    note_fault($sformatf("unexpected result status=%0d index=%0d",
                                         response.status, response.index));
                else
                begin
                    want = due_results.pop_front();
                    if (response.status !== want.status)
                        note_fault($sformatf("status expected %0d got %0d (index %0d)",
                                             want.status, response.status, want.index));
                    if (response.index !== want.index)
                        note_fault($sformatf("index expected %0d got %0d (status %0d)",
                                             want.index, response.index, want.status));
                end
            end
        end
        req_taken <= rst_n && push && !full;
        rsp_taken <= rst_n && pop && !empty;
    end

    // Sender: hold the offered byte until taken, then idle the next byte's gap
    always @(negedge clk)
    begin
        logic busy;
        char_slot_t slot;
        busy = push && !req_taken;
        if (rst_n && !busy)
        begin
            if (pending.size() == 0)
                push <= 1'b0;
            else if (idle_done >= pending[0].gap)
            begin
                slot = pending.pop_front();
                request <= slot.req;
                push <= 1'b1;
                idle_done = 0;
            end
            else
            begin
                push <= 1'b0;
                idle_done++;
            end
        end
    end

    // Receiver: idle a drawn number of cycles after each result; every third
    // run of eight results goes without idling
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
                rx_left = ((result_cnt / 8) % 3 == 0) ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_rx || rx_left > 0)
            begin
                pop <= 1'b0;
                if (rx_left > 0)
                    rx_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    // Hold off the receiver for a long stretch while bytes keep coming
    initial
    begin
        @(posedge clk);
        while (taken_cnt < hold_at)
            @(negedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES)
            @(negedge clk);
        hold_rx <= 1'b0;
    end

    // Guard against a hung handshake
    initial
    begin
        #5_000_000;
        $display("closing_brace_finder regression: fail");
        $finish;
    end

    initial
    begin
        int unsigned random_start;
        bit calm;

        // Scripted strings
        draft = {CHAR_OPEN_CURLY, CHAR_CLOSE_CURLY};                     // match on last byte
        commit_string(0);
        draft = {CHAR_OPEN_PAREN};                                       // opener is also last
        commit_string(0);
        draft = {8'hFF, CHAR_CLOSE_PAREN};                               // bad opener, rest dropped
        commit_string(0);
        draft = {CHAR_OPEN_PAREN, CHAR_BACKSLASH, CHAR_CLOSE_PAREN,      // escaped closer
                 CHAR_CLOSE_PAREN};
        commit_string(0);
        draft = {CHAR_OPEN_PAREN, CHAR_BACKSLASH, CHAR_BACKSLASH,        // backslash pair escapes
                 CHAR_CLOSE_PAREN};
        commit_string(0);
        draft = {CHAR_OPEN_CURLY, CHAR_SQUOTE, CHAR_CLOSE_CURLY,         // closer inside quotes,
                 CHAR_BACKSLASH, CHAR_SQUOTE, CHAR_SQUOTE,               // escaped quote inside,
                 CHAR_CLOSE_CURLY, 8'h00};                               // trailing byte dropped
        commit_string(0);
        draft = {CHAR_OPEN_PAREN, CHAR_BACKSLASH, CHAR_DQUOTE,           // escaped quote opens
                 CHAR_OPEN_CURLY, CHAR_CLOSE_PAREN};                     // nothing; other kind
        commit_string(0);
        draft = {CHAR_OPEN_PAREN, CHAR_BQUOTE, CHAR_CLOSE_PAREN, 8'h00}; // unclosed back quote
        commit_string(0);

        // Random strings; the long hold-off starts a little way in
        hold_at = queued_cnt + 60;
        random_start = queued_cnt;
        while (queued_cnt - random_start < 400)
        begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:
                begin
                    draft = {};
                    repeat ($urandom_range(1, 8))
                        draft.push_back(rand_char());
                end
                1:
                begin
                    make_balanced();
                    draft = draft[0:$urandom_range(0, draft.size() - 1)];
                end
                default:
                    make_balanced();
            endcase
            commit_string(calm);
        end
        draft = {};

        rst_n = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (taken_cnt < queued_cnt)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fault_cnt == 0 && due_results.size() == 0)
            $display("closing_brace_finder regression: pass");
        else
            $display("closing_brace_finder regression: fail");
        $finish;
    end

endmodule
